[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising edge while out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/cfr_pkg.sv]
// Shared types and constants of the checksummed frame receiver.
// No dependencies.
package cfr_pkg;

    localparam logic [7:0]  HEAD_FIRST    = 8'hFA;
    localparam logic [7:0]  TAIL_BYTE     = 8'hFC;
    // Second head byte: 0x5A out of reset, set through CFG_RX_HEAD.
    localparam logic [7:0]  RX_HEAD_RESET = 8'h5A;
    localparam logic [15:0] MAX_LEN_RESET = 16'd248;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_OK      = 3'd2,
        KIND_BADSUM  = 3'd3,
        KIND_TOOLONG = 3'd4,
        KIND_BADTAIL = 3'd5
    } t_kind;

    typedef struct packed {
        logic        frame_end;
        t_kind       kind;
        logic [15:0] received_sum;
        logic [15:0] computed_sum;
        logic [15:0] frame_len;
        logic [7:0]  frame_cmd;
        logic [15:0] byte_index;
        logic [7:0]  payload_byte;
    } t_result;

endpackage

[sv/cfr_out_skid.sv]
// Two-entry output register with skid stage for result requests.
// Depends on cfr_pkg (t_result).
module cfr_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cfr_pkg::t_result i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cfr_pkg::t_result o_out_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    cfr_pkg::t_result r_main;
    cfr_pkg::t_result r_skid;
    logic             in_fire;
    logic             out_fire;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_main_valid && i_out_ready;
    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_main <= i_in_data;
            end else begin
                r_main_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_main_valid) begin
                // main is stalled: park the new request
                r_skid       <= i_in_data;
                r_skid_valid <= 1'b1;
            end else begin
                r_main       <= i_in_data;
                r_main_valid <= 1'b1;
            end
        end
    end

endmodule

[sv/checksummed_frame_receiver.sv]
// Checksummed frame receiver: frame hunt, checksum and payload streaming.
// Depends on cfr_pkg and cfr_out_skid.
// Each result is registered in the output stage (main, or skid while main waits).
// Throughput: one byte per cycle while the master side takes results; the output
//   skid stage keeps the slave side open for one more request while a result waits.
// Reset (synchronous, i_rst_n low): hunt for first head byte, per-frame state
//   zero, registers back to 0x5A and 248, output side empty.
module checksummed_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] rx_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] payload_byte, [23:8] byte_index, [31:24] frame_cmd,
    // [47:32] frame_len, [63:48] computed_sum, [79:64] received_sum
    output logic [79:0]                         o_m_axis_tdata,
    output logic [2:0]                          o_m_axis_tuser,  // [2:0] kind
    output logic                                o_m_axis_tlast   // frame_end
);

    typedef enum logic [8:0] {
        PH_HEAD1 = 9'b000000001,
        PH_HEAD2 = 9'b000000010,
        PH_LEN1  = 9'b000000100,
        PH_LEN2  = 9'b000001000,
        PH_CMD   = 9'b000010000,
        PH_DATA  = 9'b000100000,
        PH_CS1   = 9'b001000000,
        PH_CS2   = 9'b010000000,
        PH_TAIL  = 9'b100000000
    } t_phase;

    logic [7:0]  r_rx_head;
    logic [15:0] r_max_len;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_exp_len, n_exp_len;
    logic [7:0]  r_cmd,     n_cmd;
    logic [15:0] r_count,   n_count;
    logic [15:0] r_sum,     n_sum;
    logic [7:0]  r_cs_lo,   n_cs_lo;
    logic [7:0]  r_cs_hi,   n_cs_hi;

    logic             s_fire;
    logic [7:0]       b;
    logic [15:0]      sum_plus_b;
    logic [15:0]      count_plus1;
    cfr_pkg::t_kind   kind;
    logic [7:0]       pbyte;
    logic [15:0]      pidx;
    cfr_pkg::t_result res;
    cfr_pkg::t_result m_data;

    assign b           = i_s_axis_tdata;
    assign s_fire      = i_s_axis_tvalid && o_s_axis_tready;
    assign sum_plus_b  = r_sum + {8'd0, b};
    assign count_plus1 = r_count + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= cfr_pkg::RX_HEAD_RESET;
            r_max_len <= cfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfr_pkg::CFG_RX_HEAD: r_rx_head <= i_cfg_wdata[7:0];
                cfr_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_cmd     = r_cmd;
        n_count   = r_count;
        n_sum     = r_sum;
        n_cs_lo   = r_cs_lo;
        n_cs_hi   = r_cs_hi;
        kind      = cfr_pkg::KIND_NONE;
        pbyte     = 8'd0;
        pidx      = 16'd0;
        unique case (r_phase)
            PH_HEAD1: begin
                if (b == cfr_pkg::HEAD_FIRST) n_phase = PH_HEAD2;
            end
            PH_HEAD2: begin
                if (b == r_rx_head) begin
                    n_exp_len = 16'd0;
                    n_cmd     = 8'd0;
                    n_count   = 16'd0;
                    n_cs_lo   = 8'd0;
                    n_cs_hi   = 8'd0;
                    n_sum     = {8'd0, cfr_pkg::HEAD_FIRST} + {8'd0, b};
                    n_phase   = PH_LEN1;
                end else if (b != cfr_pkg::HEAD_FIRST) begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_LEN1: begin
                n_exp_len = {8'd0, b};
                n_sum     = sum_plus_b;
                n_phase   = PH_LEN2;
            end
            PH_LEN2: begin
                n_exp_len = {b, r_exp_len[7:0]};
                n_sum     = sum_plus_b;
                if ({b, r_exp_len[7:0]} > r_max_len) begin
                    kind    = cfr_pkg::KIND_TOOLONG;
                    n_phase = PH_HEAD1;
                end else begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_cmd   = b;
                n_sum   = sum_plus_b;
                n_count = 16'd0;
                n_phase = (r_exp_len != 16'd0) ? PH_DATA : PH_CS1;
            end
            PH_DATA: begin
                kind    = cfr_pkg::KIND_PAYLOAD;
                pbyte   = b;
                pidx    = r_count;
                n_sum   = sum_plus_b;
                n_count = count_plus1;
                if (count_plus1 >= r_exp_len) n_phase = PH_CS1;
            end
            PH_CS1: begin
                n_cs_lo = b;
                n_phase = PH_CS2;
            end
            PH_CS2: begin
                n_cs_hi = b;
                n_phase = PH_TAIL;
            end
            PH_TAIL: begin
                if (b == cfr_pkg::TAIL_BYTE) begin
                    kind    = ({r_cs_hi, r_cs_lo} == r_sum) ? cfr_pkg::KIND_OK
                                                            : cfr_pkg::KIND_BADSUM;
                    n_phase = PH_HEAD1;
                end else begin
                    // a start byte in tail position reopens the hunt mid-header
                    kind    = cfr_pkg::KIND_BADTAIL;
                    n_phase = (b == cfr_pkg::HEAD_FIRST) ? PH_HEAD2 : PH_HEAD1;
                end
            end
            default: n_phase = PH_HEAD1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD1;
            r_exp_len <= 16'd0;
            r_cmd     <= 8'd0;
            r_count   <= 16'd0;
            r_sum     <= 16'd0;
            r_cs_lo   <= 8'd0;
            r_cs_hi   <= 8'd0;
        end else if (s_fire) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_cmd     <= n_cmd;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_cs_lo   <= n_cs_lo;
            r_cs_hi   <= n_cs_hi;
        end
    end

    always_comb begin
        res.kind         = kind;
        res.payload_byte = pbyte;
        res.byte_index   = pidx;
        res.frame_cmd    = n_cmd;
        res.frame_len    = n_exp_len;
        res.computed_sum = n_sum;
        res.received_sum = {n_cs_hi, n_cs_lo};
        res.frame_end    = (kind == cfr_pkg::KIND_OK) || (kind == cfr_pkg::KIND_BADSUM) ||
                           (kind == cfr_pkg::KIND_TOOLONG) || (kind == cfr_pkg::KIND_BADTAIL);
    end

    cfr_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_data   (res),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (m_data)
    );

    assign o_m_axis_tdata = {m_data.received_sum, m_data.computed_sum, m_data.frame_len,
                             m_data.frame_cmd, m_data.byte_index, m_data.payload_byte};
    assign o_m_axis_tuser = m_data.kind;
    assign o_m_axis_tlast = m_data.frame_end;

endmodule

[sv/cfr_checker.sv]
// Port-level checks of the checksummed frame receiver, bound to the top level.
// Depends on cfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    logic        is_payload;
    logic        is_end_kind;
    logic        m_valid;
    logic        last_ok;
    logic        idx_ok;
    logic        zero_ok;
    logic        stall;
    logic [83:0] m_bus;

    assign is_payload  = (o_m_axis_tuser == cfr_pkg::KIND_PAYLOAD);
    assign is_end_kind = (o_m_axis_tuser == cfr_pkg::KIND_OK) ||
                         (o_m_axis_tuser == cfr_pkg::KIND_BADSUM) ||
                         (o_m_axis_tuser == cfr_pkg::KIND_TOOLONG) ||
                         (o_m_axis_tuser == cfr_pkg::KIND_BADTAIL);

    assign m_valid = o_m_axis_tvalid;
    // tlast marks exactly the requests that close or drop a frame
    assign last_ok = !m_valid || (o_m_axis_tlast == is_end_kind);
    // a payload byte lies inside the declared length
    assign idx_ok  = !(m_valid && is_payload) ||
                     (o_m_axis_tdata[23:8] < o_m_axis_tdata[47:32]);
    // byte and index are zero outside payload requests
    assign zero_ok = !m_valid || is_payload || (o_m_axis_tdata[23:0] == 24'd0);
    assign stall   = m_valid && !i_m_axis_tready;
    assign m_bus   = {o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};

    `ASSERT_CLKD(a_last_kind, i_clk, i_rst_n, last_ok, "tlast does not match kind")
    `ASSERT_CLKD(a_idx_in_len, i_clk, i_rst_n, idx_ok, "payload index beyond length")
    `ASSERT_CLKD(a_non_payload_zero, i_clk, i_rst_n, zero_ok, "payload fields set")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, m_valid && $stable(m_bus), "stall not held")

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[test/tb_checksummed_frame_receiver.sv]
// Self-checking testbench for checksummed_frame_receiver: frame stream in, per-byte results out.
// Needs cfr_pkg and the RTL of the block; the expected results come from the behavioral
// frame_scoreboard class below and are checked field by field, in order.
module tb_checksummed_frame_receiver;

    typedef enum logic [3:0] {
        ST_HEAD1, ST_HEAD2, ST_LEN_LO, ST_LEN_HI, ST_CMD,
        ST_PAYLOAD, ST_SUM_LO, ST_SUM_HI, ST_TAIL
    } t_rx_state;

    class frame_scoreboard;
        logic [7:0]       head2_cfg;
        logic [15:0]      len_limit;
        t_rx_state        state;
        logic [15:0]      decl_len;
        logic [7:0]       cmd;
        logic [15:0]      pay_count;
        logic [15:0]      run_sum;
        logic [7:0]       sum_lo;
        logic [7:0]       sum_hi;
        cfr_pkg::t_result expected_q[$];
        int               errors;

        function new();
            head2_cfg = cfr_pkg::RX_HEAD_RESET;
            len_limit = cfr_pkg::MAX_LEN_RESET;
            state     = ST_HEAD1;
            decl_len  = '0;
            cmd       = '0;
            pay_count = '0;
            run_sum   = '0;
            sum_lo    = '0;
            sum_hi    = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                              logic [cfr_pkg::CFG_DATA_W-1:0] data);
            if (idx == cfr_pkg::CFG_RX_HEAD)
                head2_cfg = data[7:0];
            else if (idx == cfr_pkg::CFG_MAX_LEN)
                len_limit = data;
        endfunction

        // Advance the frame hunt by one received byte and queue the result it gives.
        function void note_byte(logic [7:0] b);
            cfr_pkg::t_result r;
            r = '0;
            r.kind = cfr_pkg::KIND_NONE;
            case (state)
                ST_HEAD1: begin
                    if (b == cfr_pkg::HEAD_FIRST)
                        state = ST_HEAD2;
                end
                ST_HEAD2: begin
                    if (b == head2_cfg) begin
                        decl_len  = '0;
                        cmd       = '0;
                        pay_count = '0;
                        sum_lo    = '0;
                        sum_hi    = '0;
                        run_sum   = 16'(cfr_pkg::HEAD_FIRST) + 16'(b);
                        state     = ST_LEN_LO;
                    end else if (b != cfr_pkg::HEAD_FIRST) begin
                        state = ST_HEAD1;
                    end
                end
                ST_LEN_LO: begin
                    decl_len = {8'h00, b};
                    run_sum  = run_sum + 16'(b);
                    state    = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    decl_len[15:8] = b;
                    run_sum        = run_sum + 16'(b);
                    if (decl_len > len_limit) begin
                        r.kind = cfr_pkg::KIND_TOOLONG;
                        state  = ST_HEAD1;
                    end else begin
                        state = ST_CMD;
                    end
                end
                ST_CMD: begin
                    cmd       = b;
                    run_sum   = run_sum + 16'(b);
                    pay_count = '0;
                    state     = (decl_len != 0) ? ST_PAYLOAD : ST_SUM_LO;
                end
                ST_PAYLOAD: begin
                    r.kind         = cfr_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = pay_count;
                    run_sum        = run_sum + 16'(b);
                    pay_count      = pay_count + 16'd1;
                    if (pay_count >= decl_len)
                        state = ST_SUM_LO;
                end
                ST_SUM_LO: begin
                    sum_lo = b;
                    state  = ST_SUM_HI;
                end
                ST_SUM_HI: begin
                    sum_hi = b;
                    state  = ST_TAIL;
                end
                ST_TAIL: begin
                    if (b == cfr_pkg::TAIL_BYTE) begin
                        r.kind = ({sum_hi, sum_lo} == run_sum) ? cfr_pkg::KIND_OK
                                                               : cfr_pkg::KIND_BADSUM;
                        state  = ST_HEAD1;
                    end else begin
                        r.kind = cfr_pkg::KIND_BADTAIL;
                        state  = (b == cfr_pkg::HEAD_FIRST) ? ST_HEAD2 : ST_HEAD1;
                    end
                end
                default: state = ST_HEAD1;
            endcase
            r.frame_cmd    = cmd;
            r.frame_len    = decl_len;
            r.computed_sum = run_sum;
            r.received_sum = {sum_hi, sum_lo};
            r.frame_end    = (r.kind >= cfr_pkg::KIND_OK);
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [15:0] got_v, logic [15:0] want_v);
            errors++;
            if (errors <= 100)
                $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
        endtask

        task check_result(logic [79:0] data, logic [2:0] user, logic last);
            cfr_pkg::t_result got;
            cfr_pkg::t_result want;
            got = {last, user, data};
            if (expected_q.size() == 0) begin
                report("result with nothing pending", 16'(got.kind), 16'(cfr_pkg::KIND_NONE));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind != want.kind)
                report("kind", 16'(got.kind), 16'(want.kind));
            if (got.payload_byte != want.payload_byte)
                report("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
            if (got.byte_index != want.byte_index)
                report("byte_index", got.byte_index, want.byte_index);
            if (got.frame_cmd != want.frame_cmd)
                report("frame_cmd", 16'(got.frame_cmd), 16'(want.frame_cmd));
            if (got.frame_len != want.frame_len)
                report("frame_len", got.frame_len, want.frame_len);
            if (got.computed_sum != want.computed_sum)
                report("computed_sum", got.computed_sum, want.computed_sum);
            if (got.received_sum != want.received_sum)
                report("received_sum", got.received_sum, want.received_sum);
            if (got.frame_end != want.frame_end)
                report("frame_end", 16'(got.frame_end), 16'(want.frame_end));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_we        = 1'b0;
    logic [cfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [cfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [7:0]                     i_s_axis_tdata  = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [79:0]                    o_m_axis_tdata;
    logic [2:0]                     o_m_axis_tuser;
    logic                           o_m_axis_tlast;

    checksummed_frame_receiver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    frame_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int bytes_sent    = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sink side: random back-pressure and result checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Write enable drops for one cycle after each write.
    task automatic write_reg(input logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Full frame with random payload; corrupt flips one checksum bit.
    task automatic send_frame(input logic [7:0] head2, input logic [15:0] len,
                              input logic [7:0] cmd, input bit corrupt,
                              input logic [7:0] tail);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = 16'(cfr_pkg::HEAD_FIRST) + 16'(head2) + 16'(len[7:0]) + 16'(len[15:8])
            + 16'(cmd);
        send_byte(cfr_pkg::HEAD_FIRST);
        send_byte(head2);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(cmd);
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom);
            sum = sum + 16'(b);
            send_byte(b);
        end
        if (corrupt)
            sum = sum ^ (16'd1 << $urandom_range(15));
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
        send_byte(tail);
    endtask

    function automatic logic [15:0] pick_len();
        int cap;
        cap = ($urandom_range(19) == 0) ? 40 : 12;
        if (cap > sb.len_limit)
            cap = sb.len_limit;
        return 16'($urandom_range(cap));
    endfunction

    task automatic send_random(input int n_bytes);
        int          pick;
        int          lim;
        logic [15:0] len;
        logic [7:0]  b;
        bytes_sent = 0;
        while (bytes_sent < n_bytes) begin
            pick = $urandom_range(99);
            lim  = sb.len_limit;
            if (pick < 60) begin
                send_frame(sb.head2_cfg, pick_len(), 8'($urandom), 1'b0, cfr_pkg::TAIL_BYTE);
            end else if (pick < 70) begin
                send_frame(sb.head2_cfg, pick_len(), 8'($urandom), 1'b1, cfr_pkg::TAIL_BYTE);
            end else if (pick < 76 && lim < 65535) begin
                // oversize: dropped right after the length bytes
                len = $urandom_range(1) ? 16'(lim + 1)
                                        : 16'(lim + 1 + $urandom_range(65534 - lim));
                send_byte(cfr_pkg::HEAD_FIRST);
                send_byte(sb.head2_cfg);
                send_byte(len[7:0]);
                send_byte(len[15:8]);
            end else if (pick < 84) begin
                b = $urandom_range(1) ? cfr_pkg::HEAD_FIRST : 8'($urandom);
                if (b == cfr_pkg::TAIL_BYTE)
                    b = b ^ 8'h01;
                send_frame(sb.head2_cfg, pick_len(), 8'($urandom), $urandom_range(1), b);
            end else if (pick < 90) begin
                b = 8'($urandom);
                if (b == sb.head2_cfg)
                    b = ~b;
                send_byte(cfr_pkg::HEAD_FIRST);
                send_byte(b);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    localparam int N_SETS = 5;
    logic [7:0]  set_head [N_SETS] = '{8'h5A, 8'h5B, 8'hFF, 8'h00, 8'hFA};
    logic [15:0] set_limit[N_SETS] = '{16'd248, 16'd0, 16'hFFFF, 16'd5, 16'd16};
    int          set_src  [N_SETS] = '{18, 18, 52, 52, 0};
    int          set_sink [N_SETS] = '{52, 52, 18, 18, 0};
    int          set_bytes[N_SETS] = '{150, 75, 75, 75, 75};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < N_SETS; s++) begin
            wait_drained();
            write_reg(cfr_pkg::CFG_RX_HEAD, 16'(set_head[s]));
            write_reg(cfr_pkg::CFG_MAX_LEN, set_limit[s]);
            src_idle_pct  = set_src[s];
            sink_idle_pct = set_sink[s];
            if (s == 0) begin
                // repeated first head byte, then a zero-length frame
                send_byte(cfr_pkg::HEAD_FIRST);
                send_frame(8'h5A, 16'd0, 8'hFF, 1'b0, cfr_pkg::TAIL_BYTE);
                // length one above the limit
                send_byte(cfr_pkg::HEAD_FIRST);
                send_byte(8'h5A);
                send_byte(8'hF9);
                send_byte(8'h00);
                // wrong second head byte
                send_byte(cfr_pkg::HEAD_FIRST);
                send_byte(8'h11);
                send_frame(8'h5A, 16'd1, 8'h00, 1'b1, cfr_pkg::TAIL_BYTE);
                // head byte in the tail slot resumes the hunt at the second head byte
                send_frame(8'h5A, 16'd0, 8'h3C, 1'b0, cfr_pkg::HEAD_FIRST);
            end
            send_random(set_bytes[s]);
            i_s_axis_tvalid <= 1'b0;
        end
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report("results never arrived", 16'(sb.expected_q.size()), 16'd0);
        if (sb.errors == 0)
            $display("checksummed_frame_receiver test passed");
        else
            $display("checksummed_frame_receiver test failed");
        $finish;
    end

    initial begin
        #400000;
        $display("checksummed_frame_receiver test failed");
        $finish;
    end

endmodule
